// File: rtl/pst_pkg.sv
`default_nettype none

package pst_pkg;

    localparam int ENTRIES = 256;
    localparam int PRIO_W = 32;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EIDX_W = (IDX_W > 8) ? IDX_W : 8;
    localparam int EXT_W = (PRIO_W > 32) ? PRIO_W : 32;

    typedef enum logic [1:0] {
        REQ_WR_PRIO = 2'd0,
        REQ_WR_COMM = 2'd1,
        REQ_READ    = 2'd2,
        REQ_FIND    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_SLAST,
        ST_POST
    } state_t;

    typedef struct packed {
        logic              wr_prio;
        logic              wr_comm;
        logic              rd;
        logic [IDX_W-1:0]  wr_addr;
        logic [IDX_W-1:0]  rd_addr;
        logic [PRIO_W-1:0] wr_key;
        logic              wr_comm_val;
    } tbl_req_t;

    // offset-binary key: sign bit flipped so the minimum priority is key 0
    function automatic logic [PRIO_W-1:0] key_from_input(input logic signed [31:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[PRIO_W-1:0] ^ {1'b1, {(PRIO_W-1){1'b0}}};
    endfunction

    function automatic logic signed [31:0] key_to_output(input logic [PRIO_W-1:0] k);
        logic signed [PRIO_W-1:0] v;
        logic [EXT_W-1:0] ext;
        v = k ^ {1'b1, {(PRIO_W-1){1'b0}}};
        ext = EXT_W'(v);
        return ext[31:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/pst_table.sv
`default_nettype none

module pst_table (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire pst_pkg::tbl_req_t         req_i,
    output logic [pst_pkg::PRIO_W-1:0]     rd_key_o,
    output logic                           rd_comm_o
);
    import pst_pkg::*;

    logic [PRIO_W-1:0] prio_mem [ENTRIES];
    logic              comm_mem [ENTRIES];

    logic [ENTRIES-1:0] vld_reg;
    logic [PRIO_W-1:0]  key_q_reg;
    logic               comm_q_reg;
    logic               vld_q_reg;
    logic               wr_first;

    assign wr_first = !vld_reg[req_i.wr_addr];

    // the first write to an entry also clears its other field
    always_ff @(posedge aclk) begin
        if (req_i.wr_prio) begin
            prio_mem[req_i.wr_addr] <= req_i.wr_key;
        end else if (req_i.wr_comm && wr_first) begin
            prio_mem[req_i.wr_addr] <= '0;
        end
        if (req_i.wr_comm) begin
            comm_mem[req_i.wr_addr] <= req_i.wr_comm_val;
        end else if (req_i.wr_prio && wr_first) begin
            comm_mem[req_i.wr_addr] <= 1'b0;
        end
        if (req_i.rd) begin
            key_q_reg  <= prio_mem[req_i.rd_addr];
            comm_q_reg <= comm_mem[req_i.rd_addr];
        end
    end

    // per-entry written flags stand in for the reset contents
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (req_i.wr_prio || req_i.wr_comm) begin
                vld_reg[req_i.wr_addr] <= 1'b1;
            end
            if (req_i.rd) begin
                vld_q_reg <= vld_reg[req_i.rd_addr];
            end
        end
    end

    assign rd_key_o  = vld_q_reg ? key_q_reg : '0;
    assign rd_comm_o = vld_q_reg ? comm_q_reg : 1'b0;

endmodule

`default_nettype wire

// File: rtl/uncommitted_priority_select_table.sv
// throughput: one request at a time; the search reads one table entry per cycle
//   through the single memory read port
// reset: synchronous active-low aresetn; all entries read as minimum priority and
//   uncommitted right after reset, with no clearing pass
`default_nettype none

module uncommitted_priority_select_table (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_req_type,
    input  wire logic [7:0]         s_entry_index,
    input  wire logic signed [31:0] s_new_priority,
    input  wire logic               s_new_committed,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_read_priority,
    output logic                    m_read_committed,
    output logic [7:0]              m_best_index,
    output logic                    m_best_found
);
    import pst_pkg::*;

    state_t state_reg, state_next;
    tbl_req_t tbl_req;

    logic [PRIO_W-1:0] rd_key;
    logic              rd_comm;

    logic [EIDX_W-1:0] idx_ext;
    logic [IDX_W-1:0]  idx_addr;
    logic              idx_inside;
    logic              accept;
    logic              out_free;
    logic              scan_last;
    req_t              req;

    logic [IDX_W-1:0]  cnt_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              inside_reg;
    logic [PRIO_W-1:0] best_key_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic signed [31:0] res_prio_reg;
    logic              res_comm_reg;
    logic              m_valid_reg;
    logic [EIDX_W-1:0] best_idx_ext;

    assign idx_ext    = EIDX_W'(s_entry_index);
    assign idx_addr   = idx_ext[IDX_W-1:0];
    assign idx_inside = {1'b0, idx_ext} < (EIDX_W + 1)'(ENTRIES);
    assign req        = req_t'(s_req_type);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign scan_last  = cnt_reg == IDX_W'(ENTRIES - 1);
    assign best_idx_ext = EIDX_W'(best_idx_reg);

    pst_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_i     (tbl_req),
        .rd_key_o  (rd_key),
        .rd_comm_o (rd_comm)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (req)
                        REQ_READ: state_next = ST_READ;
                        REQ_FIND: state_next = ST_SCAN;
                        default:  state_next = ST_POST;
                    endcase
                end
            end
            ST_READ:  state_next = ST_POST;
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_SLAST;
                end
            end
            ST_SLAST: state_next = ST_POST;
            ST_POST: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready             = 1'b0;
        tbl_req             = '0;
        tbl_req.wr_addr     = idx_addr;
        tbl_req.rd_addr     = idx_addr;
        tbl_req.wr_key      = key_from_input(s_new_priority);
        tbl_req.wr_comm_val = s_new_committed;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready         = 1'b1;
                tbl_req.wr_prio = s_valid && idx_inside && (req == REQ_WR_PRIO);
                tbl_req.wr_comm = s_valid && idx_inside && (req == REQ_WR_COMM);
                tbl_req.rd      = s_valid && (req == REQ_READ);
            end
            ST_SCAN: begin
                tbl_req.rd      = 1'b1;
                tbl_req.rd_addr = cnt_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= state_reg == ST_SCAN;
            if (state_reg == ST_POST && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            inside_reg   <= idx_inside;
            cnt_reg      <= '0;
            best_key_reg <= '0;
            best_idx_reg <= '0;
            res_prio_reg <= '0;
            res_comm_reg <= 1'b0;
        end
        if (state_reg == ST_SCAN) begin
            cnt_reg     <= cnt_reg + 1'b1;
            cmp_idx_reg <= cnt_reg;
        end
        // strictly greater wins, so ties keep the lower index
        if (cmp_vld_reg && !rd_comm && rd_key > best_key_reg) begin
            best_key_reg <= rd_key;
            best_idx_reg <= cmp_idx_reg;
        end
        if (state_reg == ST_READ) begin
            res_prio_reg <= key_to_output(inside_reg ? rd_key : '0);
            res_comm_reg <= inside_reg && rd_comm;
        end
        if (state_reg == ST_POST && out_free) begin
            m_read_priority  <= res_prio_reg;
            m_read_committed <= res_comm_reg;
            m_best_found     <= best_key_reg != '0;
            m_best_index     <= best_idx_ext[7:0];
        end
    end

    assign m_valid = m_valid_reg;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("transfer accepted while a request is in progress");

    a_found_excludes_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_best_found) |-> (m_read_priority == 0 && !m_read_committed))
        else $error("search result carries read fields");

    a_not_found_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_best_found) |-> (m_best_index == 8'd0))
        else $error("nonzero index without a found entry");

    a_scan_ends_posting: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLAST) |=> (state_reg == ST_POST))
        else $error("search did not finish into result posting");

endmodule

`default_nettype wire

// File: test/uncommitted_priority_select_table_tb.sv
`default_nettype none

module uncommitted_priority_select_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pst_pkg::*;

    localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] PRIO_MAX = 32'sh7fff_ffff;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD = 500;
    localparam int PHASE_ITEMS = 250;

    typedef struct {
        req_t               req;
        logic [7:0]         idx;
        logic signed [31:0] prio;
        logic               comm;
    } table_request_t;

    typedef struct {
        logic signed [31:0] read_priority;
        logic               read_committed;
        logic [7:0]         best_index;
        logic               best_found;
    } table_answer_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type = 2'd0;
    logic [7:0]         s_entry_index = 8'd0;
    logic signed [31:0] s_new_priority = 32'sd0;
    logic               s_new_committed = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_read_priority;
    logic               m_read_committed;
    logic [7:0]         m_best_index;
    logic               m_best_found;

    table_request_t pending_requests[$];
    table_answer_t  expected_answers[$];
    table_request_t cur_request;

    logic signed [31:0] prio_table [ENTRIES];
    logic               commit_table [ENTRIES];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_arm = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int n_errors = 0;
    int n_answers = 0;
    int n_found = 0;
    int n_by_req [4] = '{0, 0, 0, 0};

    uncommitted_priority_select_table u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_entry_index    (s_entry_index),
        .s_new_priority   (s_new_priority),
        .s_new_committed  (s_new_committed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_priority  (m_read_priority),
        .m_read_committed (m_read_committed),
        .m_best_index     (m_best_index),
        .m_best_found     (m_best_found)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // table model: update on each accepted request and queue the answer it owes
    task automatic apply_request(input table_request_t r);
        table_answer_t a;
        logic signed [31:0] best_prio;
        bit in_range;
        a = '{read_priority: 32'sd0, read_committed: 1'b0, best_index: 8'd0, best_found: 1'b0};
        in_range = int'(r.idx) < ENTRIES;
        case (r.req)
            REQ_WR_PRIO: begin
                if (in_range) prio_table[r.idx] = r.prio;
            end
            REQ_WR_COMM: begin
                if (in_range) commit_table[r.idx] = r.comm;
            end
            REQ_READ: begin
                a.read_priority = in_range ? prio_table[r.idx] : PRIO_MIN;
                a.read_committed = in_range ? commit_table[r.idx] : 1'b0;
            end
            default: begin
                best_prio = PRIO_MIN;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!commit_table[i] && prio_table[i] > best_prio) begin
                        best_prio = prio_table[i];
                        a.best_index = 8'(i);
                        a.best_found = 1'b1;
                    end
                end
                if (a.best_found) n_found++;
            end
        endcase
        n_by_req[r.req]++;
        expected_answers.insert(expected_answers.size(), a);
    endtask

    task automatic add_request(input table_request_t r);
        pending_requests.insert(pending_requests.size(), r);
    endtask

    function automatic table_request_t mk_request(req_t req, logic [7:0] idx,
                                                  logic signed [31:0] prio, logic comm);
        table_request_t r;
        r.req = req;
        r.idx = idx;
        r.prio = prio;
        r.comm = comm;
        return r;
    endfunction

    function automatic table_request_t rand_request();
        table_request_t r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) r.req = REQ_WR_PRIO;
        else if (pick < 60) r.req = REQ_WR_COMM;
        else if (pick < 85) r.req = REQ_READ;
        else r.req = REQ_FIND;
        // hot entries at both ends of the table so searches see ties and commits
        pick = $urandom_range(99);
        if (pick < 35) r.idx = 8'($urandom_range(7));
        else if (pick < 70) r.idx = 8'(248 + $urandom_range(7));
        else r.idx = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 20) r.prio = $urandom;
        else if (pick < 45) r.prio = $signed(32'($urandom_range(8))) - 32'sd4;
        else if (pick < 55) r.prio = PRIO_MIN;
        else if (pick < 65) r.prio = PRIO_MIN + 32'sd1;
        else if (pick < 75) r.prio = PRIO_MAX;
        else r.prio = 32'($urandom_range(15));
        r.comm = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s at result %0d: got %h, expected %h", field, n_answers, got,
                 want);
        n_errors++;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(cur_request);
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_request = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= cur_request.req;
                    s_entry_index <= cur_request.idx;
                    s_new_priority <= cur_request.prio;
                    s_new_committed <= cur_request.comm;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result ready, with an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_arm != hold_seen) begin
            hold_seen <= hold_arm;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        table_answer_t a;
        if (aresetn && m_valid && m_ready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected transfer", 32'd0, 32'd0);
            end else begin
                a = expected_answers.pop_front();
                if (m_read_priority !== a.read_priority)
                    report_mismatch("read_priority", m_read_priority, a.read_priority);
                if (m_read_committed !== a.read_committed)
                    report_mismatch("read_committed", 32'(m_read_committed),
                                    32'(a.read_committed));
                if (m_best_index !== a.best_index)
                    report_mismatch("best_index", 32'(m_best_index), 32'(a.best_index));
                if (m_best_found !== a.best_found)
                    report_mismatch("best_found", 32'(m_best_found), 32'(a.best_found));
            end
            n_answers++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_valid || expected_answers.size() > 0)
            @(negedge aclk);
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct, input bit hold);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        if (hold) hold_arm = ~hold_arm;
        for (int i = 0; i < PHASE_ITEMS; i++) add_request(rand_request());
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            prio_table[i] = PRIO_MIN;
            commit_table[i] = 1'b0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty table, extremes, ties, commits, minimum never found
        add_request(mk_request(REQ_FIND, 8'h3c, PRIO_MAX, 1'b1));
        add_request(mk_request(REQ_READ, 8'h00, PRIO_MAX, 1'b1));
        add_request(mk_request(REQ_READ, 8'hff, 32'sd0, 1'b0));
        add_request(mk_request(REQ_WR_PRIO, 8'hff, PRIO_MAX, 1'b1));
        add_request(mk_request(REQ_FIND, 8'h00, 32'sd0, 1'b0));
        add_request(mk_request(REQ_WR_PRIO, 8'h00, PRIO_MAX, 1'b0));
        add_request(mk_request(REQ_FIND, 8'hff, PRIO_MIN, 1'b1));
        add_request(mk_request(REQ_WR_COMM, 8'h00, PRIO_MIN, 1'b1));
        add_request(mk_request(REQ_FIND, 8'h00, 32'sd0, 1'b0));
        add_request(mk_request(REQ_READ, 8'h00, 32'sd0, 1'b0));
        add_request(mk_request(REQ_WR_COMM, 8'hff, PRIO_MAX, 1'b1));
        add_request(mk_request(REQ_FIND, 8'h00, 32'sd0, 1'b0));
        add_request(mk_request(REQ_WR_PRIO, 8'h80, PRIO_MIN + 32'sd1, 1'b1));
        add_request(mk_request(REQ_FIND, 8'h00, 32'sd0, 1'b0));
        add_request(mk_request(REQ_WR_PRIO, 8'h80, PRIO_MIN, 1'b0));
        add_request(mk_request(REQ_FIND, 8'h00, 32'sd0, 1'b0));
        add_request(mk_request(REQ_WR_PRIO, 8'haa, -32'sd1, 1'b1));
        add_request(mk_request(REQ_WR_PRIO, 8'h55, 32'sd0, 1'b0));
        add_request(mk_request(REQ_FIND, 8'h00, 32'sd0, 1'b0));
        add_request(mk_request(REQ_WR_COMM, 8'h00, 32'sh5555_5555, 1'b0));
        add_request(mk_request(REQ_FIND, 8'haa, -32'sd1, 1'b1));
        add_request(mk_request(REQ_READ, 8'haa, 32'sd0, 1'b0));
        add_request(mk_request(REQ_READ, 8'h80, 32'shaaaa_aaaa, 1'b1));
        add_request(mk_request(REQ_WR_COMM, 8'h55, PRIO_MAX, 1'b1));
        add_request(mk_request(REQ_FIND, 8'h00, 32'sd0, 1'b0));
        wait_drained();

        run_random_phase(0, 0, 1'b0);
        run_random_phase(75, 0, 1'b0);
        run_random_phase(0, 75, 1'b1);
        run_random_phase(32, 32, 1'b0);

        repeat (ENTRIES + 10) @(posedge aclk);
        $display("checked %0d results: %0d priority writes, %0d flag writes, %0d reads",
                 n_answers, n_by_req[REQ_WR_PRIO], n_by_req[REQ_WR_COMM], n_by_req[REQ_READ]);
        $display("%0d searches (%0d found an entry), %0d mismatches",
                 n_by_req[REQ_FIND], n_found, n_errors);
        if (n_errors == 0 && expected_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
